// ===== sv/cutter_path_bezier_segmenter_assert.svh =====
// assertion macros for the bezier segmenter checker
`ifndef CUTTER_PATH_BEZIER_SEGMENTER_ASSERT_SVH
`define CUTTER_PATH_BEZIER_SEGMENTER_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CPBS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off while rst_n is low
`define CPBS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cpbs_pkg.sv =====
`default_nettype none

package cpbs_pkg;

    localparam int SEGMENTS_DEF = 20;

    // device coordinates
    localparam int DEV_W = 15;
    localparam logic signed [DEV_W-1:0] DEV_MAX = 15'sd12799;

    // quotient bits of a curve point, magnitude never above 12800
    localparam int Q_W = DEV_W - 1;

    // command opcodes
    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_MOVE  = 3'd2;
    localparam logic [2:0] OP_CUT   = 3'd3;
    localparam logic [2:0] OP_CURVE = 3'd4;

    // microprogram
    localparam int PC_W = 4;

    localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] ST_MAC0  = 4'd1;
    localparam logic [PC_W-1:0] ST_MAC1  = 4'd2;
    localparam logic [PC_W-1:0] ST_MAC2  = 4'd3;
    localparam logic [PC_W-1:0] ST_MAC3  = 4'd4;
    localparam logic [PC_W-1:0] ST_SCALE = 4'd5;
    localparam logic [PC_W-1:0] ST_DIV   = 4'd6;
    localparam logic [PC_W-1:0] ST_EMIT  = 4'd7;
    localparam logic [PC_W-1:0] ST_LOOP  = 4'd8;
    localparam logic [PC_W-1:0] ST_DONE  = 4'd9;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NOT_GO,
        C_OUT_BUSY,
        C_SEG_MORE
    } cond_t;

    typedef struct packed {
        logic            accept;
        logic            mac;
        logic            mac_first;
        logic [1:0]      mac_k;
        logic            scale;
        logic            div;
        logic            emit;
        logic            next_seg;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctl_t;

    typedef struct packed {
        logic go_curve;
        logic out_busy;
        logic seg_more;
    } seq_flags_t;

    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t w;
        w = '0;
        w.cond = C_NEXT;
        w.target = ST_IDLE;
        unique case (pc)
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.cond = C_NOT_GO;
                w.target = ST_IDLE;
            end
            ST_MAC0:
            begin
                w.mac = 1'b1;
                w.mac_first = 1'b1;
                w.mac_k = 2'd0;
            end
            ST_MAC1:
            begin
                w.mac = 1'b1;
                w.mac_k = 2'd1;
            end
            ST_MAC2:
            begin
                w.mac = 1'b1;
                w.mac_k = 2'd2;
            end
            ST_MAC3:
            begin
                w.mac = 1'b1;
                w.mac_k = 2'd3;
            end
            ST_SCALE:
            begin
                w.scale = 1'b1;
            end
            ST_DIV:
            begin
                w.div = 1'b1;
            end
            ST_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = C_OUT_BUSY;
                w.target = ST_EMIT;
            end
            ST_LOOP:
            begin
                w.next_seg = 1'b1;
                w.cond = C_SEG_MORE;
                w.target = ST_MAC0;
            end
            default:
            begin
                w.cond = C_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // bernstein weight k at step i of s, scaled by s^3
    function automatic int bern_weight(input int s, input int i, input int k);
        int j;
        int r;
        j = s - i;
        case (k)
            0:       r = j * j * j;
            1:       r = 3 * i * j * j;
            2:       r = 3 * i * i * j;
            default: r = i * i * i;
        endcase
        return r;
    endfunction

    // q8.8 inches to device units, truncated toward zero
    function automatic logic signed [DEV_W-1:0] to_device(input logic signed [15:0] q);
        logic [16:0]        mag;
        logic [23:0]        m100;
        logic [15:0]        sh;
        logic signed [16:0] sv;
        mag  = q[15] ? (17'd0 - {q[15], q}) : {1'b0, q};
        m100 = 24'(mag) * 24'd100;
        sh   = m100[23:8];
        sv   = q[15] ? -$signed({1'b0, sh}) : $signed({1'b0, sh});
        return sv[DEV_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== sv/cpbs_seq.sv =====
`default_nettype none

module cpbs_seq
    import cpbs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seq_flags_t flags,
    output ctl_t       ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            hit;

    assign ctl = ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            C_NEXT:     hit = 1'b0;
            C_ALWAYS:   hit = 1'b1;
            C_NOT_GO:   hit = !flags.go_curve;
            C_OUT_BUSY: hit = flags.out_busy;
            C_SEG_MORE: hit = flags.seg_more;
            default:    hit = 1'b1;
        endcase
        pc_next = hit ? ctl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/cpbs_lane.sv =====
`default_nettype none

module cpbs_lane
    import cpbs_pkg::*;
#(
    parameter int  SEGMENTS = SEGMENTS_DEF,
    localparam int CUBE     = SEGMENTS ** 3,
    localparam int W_W      = $clog2(CUBE + 1)
)
(
    input  logic                    clk,
    input  ctl_t                    ctl,
    input  logic signed [15:0]      p0,
    input  logic signed [15:0]      p1,
    input  logic signed [15:0]      p2,
    input  logic signed [15:0]      p3,
    input  logic [W_W-1:0]          w,
    output logic signed [DEV_W-1:0] dev
);

    localparam int ACC_W = 16 + W_W + 1;
    localparam int M_W   = ACC_W + 7;
    localparam int DIV_W = W_W + Q_W;
    // reciprocal of the cube, rounded up, with a shift wide enough that the
    // product floors exactly for every scaled magnitude
    localparam int RSH   = DIV_W + W_W;
    localparam int RCP_W = RSH - W_W + 2;
    localparam int PQ_W  = DIV_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << RSH) + 64'(CUBE) - 64'd1) / 64'(CUBE));

    logic signed [ACC_W-1:0] acc_reg;
    logic                    neg_reg;
    logic [DIV_W-1:0]        rem_reg;
    logic [Q_W-1:0]          quo_reg;

    logic signed [15:0]      psel;
    logic signed [ACC_W-1:0] prod;
    logic [ACC_W-1:0]        mag;
    logic [M_W-1:0]          m100;
    logic [PQ_W-1:0]         qprod;
    logic signed [DEV_W-1:0] qs;

    always_comb
    begin
        case (ctl.mac_k)
            2'd0:    psel = p0;
            2'd1:    psel = p1;
            2'd2:    psel = p2;
            default: psel = p3;
        endcase
        prod  = psel * $signed({1'b0, w});
        mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        m100  = M_W'(mag) * M_W'(100);
        qprod = PQ_W'(rem_reg) * PQ_W'(RECIP);
        qs    = $signed({1'b0, quo_reg});
        if (neg_reg)
        begin
            dev = -qs;
        end
        else if (qs > DEV_MAX)
        begin
            dev = DEV_MAX;
        end
        else
        begin
            dev = qs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac)
        begin
            acc_reg <= ctl.mac_first ? prod : acc_reg + prod;
        end
        if (ctl.scale)
        begin
            neg_reg <= acc_reg[ACC_W-1];
            rem_reg <= m100[DIV_W+7:8];
        end
        if (ctl.div)
        begin
            // quotient by the cube through the reciprocal
            quo_reg <= qprod[RSH +: Q_W];
        end
    end

endmodule

`default_nettype wire

// ===== sv/cutter_path_bezier_segmenter.sv =====
// channel | handshake           | beat contents
// --------+---------------------+--------------------------------------------
// in      | in_valid / in_stall | opcode, pt0_x .. pt3_y (signed q8.8 inches)
// out     | out_valid/out_stall | status, has_segment, from/to x y, last
//
// start, stop, move, cut, rejected and unknown commands: the single result
// beat is registered when the command is taken
// curve: each segment is 4 multiply-accumulate steps, one scale step, one
// reciprocal multiply for the point quotient, an emit and a loop step; the
// emit step holds while out_stall keeps the output register full
// in_stall is high unless the program sits in its command step and the output
// register is free or being drained
// reset clears run flag, position, program counter and out_valid

`default_nettype none

module cutter_path_bezier_segmenter
    import cpbs_pkg::*;
#(
    parameter int  SEGMENTS = SEGMENTS_DEF,
    localparam int CUBE     = SEGMENTS ** 3,
    localparam int W_W      = $clog2(CUBE + 1),
    localparam int IDX_W    = $clog2(SEGMENTS + 1)
)
(
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [2:0]              opcode,
    input  logic signed [15:0]      pt0_x,
    input  logic signed [15:0]      pt0_y,
    input  logic signed [15:0]      pt1_x,
    input  logic signed [15:0]      pt1_y,
    input  logic signed [15:0]      pt2_x,
    input  logic signed [15:0]      pt2_y,
    input  logic signed [15:0]      pt3_x,
    input  logic signed [15:0]      pt3_y,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic                    status,
    output logic                    has_segment,
    output logic signed [DEV_W-1:0] from_x,
    output logic signed [DEV_W-1:0] from_y,
    output logic signed [DEV_W-1:0] to_x,
    output logic signed [DEV_W-1:0] to_y,
    output logic                    last
);

    // sequencer
    ctl_t       ctl;
    seq_flags_t flags;

    // engine state
    logic                    run_reg;
    logic                    run_next;
    logic signed [DEV_W-1:0] pos_x_reg;
    logic signed [DEV_W-1:0] pos_x_next;
    logic signed [DEV_W-1:0] pos_y_reg;
    logic signed [DEV_W-1:0] pos_y_next;

    // curve operands and counter
    logic signed [15:0] cx0_reg, cy0_reg, cx1_reg, cy1_reg;
    logic signed [15:0] cx2_reg, cy2_reg, cx3_reg, cy3_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;

    // output register
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    status_reg;
    logic                    has_segment_reg;
    logic signed [DEV_W-1:0] from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    logic                    last_reg;

    // handshake and command decode
    logic                    out_free;
    logic                    in_fire;
    logic                    go_curve;
    logic                    cmd_load;
    logic                    emit_fire;
    logic                    seg_more;
    logic signed [DEV_W-1:0] dev0_x, dev0_y;
    logic                    cmd_run;
    logic                    cmd_status;
    logic                    cmd_seg;
    logic signed [DEV_W-1:0] cmd_pos_x, cmd_pos_y;

    // lane results and weight lookup
    logic signed [DEV_W-1:0] pt_x, pt_y;
    logic [W_W-1:0]          wtab [4][SEGMENTS+1];
    logic [W_W-1:0]          wsel;

    // bernstein weights for every step, fixed at elaboration
    for (genvar gk = 0; gk < 4; gk++)
    begin : g_wk
        for (genvar gi = 0; gi <= SEGMENTS; gi++)
        begin : g_wi
            assign wtab[gk][gi] = W_W'(bern_weight(SEGMENTS, gi, gk));
        end
    end

    assign wsel = wtab[ctl.mac_k][idx_reg];

    // a beat is taken only in the command step with room in the output register
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = !(ctl.accept && out_free);
    assign in_fire   = in_valid && !in_stall;
    assign go_curve  = in_fire && (opcode == OP_CURVE) && run_reg;
    assign cmd_load  = in_fire && !go_curve;
    assign emit_fire = ctl.emit && out_free;
    assign seg_more  = idx_reg != IDX_W'(SEGMENTS);

    assign flags.go_curve = go_curve;
    assign flags.out_busy = !out_free;
    assign flags.seg_more = seg_more;

    cpbs_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    cpbs_lane #(.SEGMENTS(SEGMENTS)) u_lane_x
    (
        .clk (clk),
        .ctl (ctl),
        .p0  (cx0_reg),
        .p1  (cx1_reg),
        .p2  (cx2_reg),
        .p3  (cx3_reg),
        .w   (wsel),
        .dev (pt_x)
    );

    cpbs_lane #(.SEGMENTS(SEGMENTS)) u_lane_y
    (
        .clk (clk),
        .ctl (ctl),
        .p0  (cy0_reg),
        .p1  (cy1_reg),
        .p2  (cy2_reg),
        .p3  (cy3_reg),
        .w   (wsel),
        .dev (pt_y)
    );

    // single-beat commands, also the curve's new start position
    always_comb
    begin
        dev0_x     = to_device(pt0_x);
        dev0_y     = to_device(pt0_y);
        cmd_run    = run_reg;
        cmd_status = 1'b0;
        cmd_seg    = 1'b0;
        cmd_pos_x  = pos_x_reg;
        cmd_pos_y  = pos_y_reg;
        unique case (opcode) inside
            OP_START:
            begin
                cmd_run = 1'b1;
            end
            OP_STOP:
            begin
                cmd_run = 1'b0;
            end
            OP_MOVE, OP_CURVE:
            begin
                if (run_reg)
                begin
                    cmd_pos_x = dev0_x;
                    cmd_pos_y = dev0_y;
                end
                else
                begin
                    cmd_status = 1'b1;
                end
            end
            OP_CUT:
            begin
                if (run_reg)
                begin
                    cmd_seg   = 1'b1;
                    cmd_pos_x = dev0_x;
                    cmd_pos_y = dev0_y;
                end
                else
                begin
                    cmd_status = 1'b1;
                end
            end
            default:
            begin
                // unknown opcode leaves state alone
                cmd_run = run_reg;
            end
        endcase
    end

    // next state
    always_comb
    begin
        run_next   = in_fire ? cmd_run : run_reg;
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (in_fire)
        begin
            pos_x_next = cmd_pos_x;
            pos_y_next = cmd_pos_y;
        end
        else if (emit_fire)
        begin
            // each segment starts where the last one ended
            pos_x_next = pt_x;
            pos_y_next = pt_y;
        end

        idx_next = idx_reg;
        if (go_curve)
        begin
            idx_next = IDX_W'(1);
        end
        else if (ctl.next_seg && seg_more)
        begin
            idx_next = idx_reg + 1'b1;
        end

        if (cmd_load || emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg       <= run_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (go_curve)
        begin
            cx0_reg <= pt0_x;
            cy0_reg <= pt0_y;
            cx1_reg <= pt1_x;
            cy1_reg <= pt1_y;
            cx2_reg <= pt2_x;
            cy2_reg <= pt2_y;
            cx3_reg <= pt3_x;
            cy3_reg <= pt3_y;
        end
        if (cmd_load)
        begin
            // with no segment both ends carry the position after the command
            status_reg      <= cmd_status;
            has_segment_reg <= cmd_seg;
            from_x_reg      <= cmd_seg ? pos_x_reg : cmd_pos_x;
            from_y_reg      <= cmd_seg ? pos_y_reg : cmd_pos_y;
            to_x_reg        <= cmd_pos_x;
            to_y_reg        <= cmd_pos_y;
            last_reg        <= 1'b1;
        end
        else if (emit_fire)
        begin
            status_reg      <= 1'b0;
            has_segment_reg <= 1'b1;
            from_x_reg      <= pos_x_reg;
            from_y_reg      <= pos_y_reg;
            to_x_reg        <= pt_x;
            to_y_reg        <= pt_y;
            last_reg        <= !seg_more;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign has_segment = has_segment_reg;
    assign from_x      = from_x_reg;
    assign from_y      = from_y_reg;
    assign to_x        = to_x_reg;
    assign to_y        = to_y_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

// ===== sv/cpbs_checker.sv =====
`default_nettype none

`include "cutter_path_bezier_segmenter_assert.svh"

module cpbs_checker
    import cpbs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic                    status,
    input logic                    has_segment,
    input logic signed [DEV_W-1:0] from_x,
    input logic signed [DEV_W-1:0] from_y,
    input logic signed [DEV_W-1:0] to_x,
    input logic signed [DEV_W-1:0] to_y,
    input logic                    last
);

    // a beat without a segment reports one point
    `CPBS_ASSERT_IMP(a_noseg_point, out_valid && !has_segment, from_x == to_x && from_y == to_y, "no-segment beat with two points")
    // a rejected command is a single final beat with no segment
    `CPBS_ASSERT_IMP(a_reject_single, out_valid && status, !has_segment && last, "rejected beat carries a segment or is not last")
    // commands are taken only when the output register can move
    `CPBS_ASSERT_IMP(a_take_room, in_valid && !in_stall, !(out_valid && out_stall), "command taken with output blocked")
    // a stalled result stays put
    `CPBS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(to_x) && $stable(last), "stalled result changed")

endmodule

bind cutter_path_bezier_segmenter cpbs_checker u_cpbs_checker (.*);

`default_nettype wire
